FILE: hdl/lzfgd_pkg.sv
`timescale 1ns / 1ps

package lzfgd_pkg;

   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 29;
   localparam int KIND_W  = 2;
   localparam int DIST_W  = 13;
   localparam int LEN_W   = 5;
   localparam int BIT_W   = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 29'd65536;
   localparam logic [LEN_W-1:0]   LEN_BIAS    = 5'd3;
   localparam logic [BIT_W-1:0]   BIT_TOP     = 3'd7;

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

   typedef enum logic [1:0] {
      SRC_LIT,
      SRC_MEM,
      SRC_OK,
      SRC_ERR
   } emit_src_type;

   typedef struct packed {
      logic         emit;
      emit_src_type emit_src;
      logic         emit_last;
      logic         load_flag;
      logic         load_ref;
      logic         start_copy;
      logic         mem_rd;
      logic         clear_stream;
      logic         adv_bit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic eoi;
      logic lim_hit;
      logic inc_ge;
      logic flag_bit;
      logic dist_bad;
      logic copy_one;
      logic copy_zero;
      logic bit_wrap;
   } dp_stat_type;

endpackage

FILE: hdl/lz_flag_group_decoder_unit.sv
`timescale 1ns / 1ps
// LZ decoder for a flag-group (Yaz0-like) stream.
// req_*: one compressed byte per beat, req_end_of_input marks the last byte of a stream.
// rsp_*: zero or more result beats per input beat: data bytes (kind 0), then per stream
//   one "finished ok" (kind 1) or "error" (kind 2) beat, at end, limit or error.
//   rsp_run_last flags the last result beat caused by an input beat.
// csr_*: write of out_limit, the number of output bytes per stream; take it only
//   while no input beat is in work.
// Flow: one input beat in work at a time. A flag byte or the first reference byte
//   is taken in S_EXEC; a literal is loaded into the result register in S_EXEC and
//   frees the input after S_AFTER. A reference low byte copies 3 to 18 bytes:
//   each copied byte is one registered read of the 4096-byte history
//   RAM followed by a write back of the same byte.
// The result register lets the next input beat in while the last result waits.
// A stalled receiver holds the decoder in place until rsp_ready returns.
// Reset: synchronous; sets out_limit to 65536 and starts a new stream. The history
//   RAM is not cleared; only bytes written in the current stream are ever read.
module lz_flag_group_decoder_unit #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lzfgd_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                          req_end_of_input,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lzfgd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [lzfgd_pkg::KIND_W-1:0]  rsp_kind,
   output logic                          rsp_run_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lzfgd_pkg::LIMIT_W-1:0] csr_out_limit
);

   lzfgd_pkg::ctrl_cmd_type cmd;
   lzfgd_pkg::dp_stat_type  stat;
   logic                    idle;
   logic                    req_fire;
   logic                    csr_fire;

   assign req_ready = idle;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   lzfgd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .stat     (stat),
      .idle     (idle),
      .cmd      (cmd)
   );

   lzfgd_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_fire         (req_fire),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .csr_fire         (csr_fire),
      .csr_out_limit    (csr_out_limit),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_kind         (rsp_kind),
      .rsp_run_last     (rsp_run_last)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous beat still in work");

   a_status_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != lzfgd_pkg::KIND_DATA |-> rsp_run_last && rsp_out_byte == '0)
      else $error("status beat not last or carries data");

   a_kind_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != lzfgd_pkg::KIND_BAD)
      else $error("illegal result kind");

   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result loaded over a waiting beat");
`endif

endmodule

FILE: hdl/lzfgd_ctrl.sv
`timescale 1ns / 1ps

module lzfgd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  lzfgd_pkg::dp_stat_type  stat,
   output logic                    idle,
   output lzfgd_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_COPY_RD,
      S_COPY_WR,
      S_AFTER
   } state_type;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_ITEM,
      PH_REFLO,
      PH_DRAIN
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FLAG;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
               unique case (phase_ff)
                  PH_DRAIN: begin
                     if (stat.eoi) begin
                        cmd.clear_stream = 1'b1;
                        phase_in         = PH_FLAG;
                     end
                  end
                  PH_FLAG, PH_ITEM: begin
                     priority if (stat.lim_hit) begin
                        cmd.emit         = 1'b1;
                        cmd.emit_src     = lzfgd_pkg::SRC_OK;
                        cmd.emit_last    = 1'b1;
                        cmd.clear_stream = stat.eoi;
                        phase_in         = stat.eoi ? PH_FLAG : PH_DRAIN;
                     end else if (phase_ff == PH_FLAG) begin
                        cmd.load_flag = 1'b1;
                        if (stat.eoi) begin
                           cmd.emit         = 1'b1;
                           cmd.emit_src     = lzfgd_pkg::SRC_OK;
                           cmd.emit_last    = 1'b1;
                           cmd.clear_stream = 1'b1;
                           phase_in         = PH_FLAG;
                        end else begin
                           phase_in = PH_ITEM;
                        end
                     end else if (stat.flag_bit) begin
                        cmd.load_ref = 1'b1;
                        if (stat.eoi) begin
                           cmd.emit         = 1'b1;
                           cmd.emit_src     = lzfgd_pkg::SRC_ERR;
                           cmd.emit_last    = 1'b1;
                           cmd.clear_stream = 1'b1;
                           phase_in         = PH_FLAG;
                        end else begin
                           phase_in = PH_REFLO;
                        end
                     end else begin
                        cmd.emit      = 1'b1;
                        cmd.emit_src  = lzfgd_pkg::SRC_LIT;
                        cmd.emit_last = !(stat.eoi || stat.inc_ge);
                        state_in      = S_AFTER;
                     end
                  end
                  PH_REFLO: begin
                     if (stat.dist_bad) begin
                        cmd.emit         = 1'b1;
                        cmd.emit_src     = lzfgd_pkg::SRC_ERR;
                        cmd.emit_last    = 1'b1;
                        cmd.clear_stream = stat.eoi;
                        phase_in         = stat.eoi ? PH_FLAG : PH_DRAIN;
                     end else begin
                        cmd.start_copy = 1'b1;
                        state_in       = S_COPY_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_COPY_RD: begin
            if (stat.copy_zero || stat.lim_hit) begin
               state_in = S_AFTER;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_src  = lzfgd_pkg::SRC_MEM;
               cmd.emit_last = stat.copy_one && !stat.eoi && !stat.inc_ge;
               state_in      = S_COPY_RD;
            end
         end
         S_AFTER: begin
            if (stat.lim_hit || stat.eoi) begin
               if (stat.out_free) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_src     = lzfgd_pkg::SRC_OK;
                  cmd.emit_last    = 1'b1;
                  cmd.clear_stream = stat.eoi;
                  phase_in         = stat.eoi ? PH_FLAG : PH_DRAIN;
                  state_in         = S_IDLE;
               end
            end else begin
               cmd.adv_bit = 1'b1;
               phase_in    = stat.bit_wrap ? PH_FLAG : PH_ITEM;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/lzfgd_dpath.sv
`timescale 1ns / 1ps

module lzfgd_dpath #(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_fire,
   input  logic [lzfgd_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                                req_end_of_input,
   input  logic                                csr_fire,
   input  logic [lzfgd_pkg::LIMIT_W-1:0]       csr_out_limit,
   input  logic                                rsp_ready,
   input  lzfgd_pkg::ctrl_cmd_type             cmd,
   output lzfgd_pkg::dp_stat_type              stat,
   output logic                                rsp_valid,
   output logic [lzfgd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [lzfgd_pkg::KIND_W-1:0]        rsp_kind,
   output logic                                rsp_run_last
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [lzfgd_pkg::BYTE_W-1:0]  in_byte_ff;
   logic                          eoi_ff;
   logic [lzfgd_pkg::LIMIT_W-1:0] limit_ff;
   logic [lzfgd_pkg::LIMIT_W-1:0] produced_ff;
   logic [lzfgd_pkg::LIMIT_W-1:0] produced_inc;
   logic [lzfgd_pkg::BIT_W-1:0]   bit_idx_ff;
   logic [lzfgd_pkg::BYTE_W-1:0]  flag_ff;
   logic [lzfgd_pkg::BYTE_W-1:0]  ref_hi_ff;
   logic [lzfgd_pkg::DIST_W-1:0]  dist_ff;
   logic [lzfgd_pkg::DIST_W-1:0]  dist_in;
   logic [lzfgd_pkg::LEN_W-1:0]   cnt_ff;
   logic [lzfgd_pkg::BYTE_W-1:0]  rdata_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          data_emit;
   logic [lzfgd_pkg::BYTE_W-1:0]  emit_byte;

   logic [lzfgd_pkg::BYTE_W-1:0] window_mem [WINDOW_DEPTH];

   logic                          rsp_valid_ff;
   logic [lzfgd_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic [lzfgd_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic                          rsp_last_ff;

   assign produced_inc = produced_ff + lzfgd_pkg::LIMIT_W'(1);
   assign dist_in      = {ref_hi_ff[3:0], in_byte_ff} + lzfgd_pkg::DIST_W'(1);
   assign rd_addr      = produced_ff[AW-1:0] - dist_ff[AW-1:0];
   assign data_emit    = cmd.emit && (cmd.emit_src == lzfgd_pkg::SRC_LIT
                                      || cmd.emit_src == lzfgd_pkg::SRC_MEM);

   always_comb begin
      unique case (cmd.emit_src)
         lzfgd_pkg::SRC_LIT: emit_byte = in_byte_ff;
         lzfgd_pkg::SRC_MEM: emit_byte = rdata_ff;
         default:            emit_byte = '0;
      endcase
   end

   always_comb begin
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      stat.eoi       = eoi_ff;
      stat.lim_hit   = produced_ff >= limit_ff;
      stat.inc_ge    = produced_inc >= limit_ff;
      stat.flag_bit  = flag_ff[lzfgd_pkg::BIT_TOP - bit_idx_ff];
      stat.dist_bad  = lzfgd_pkg::LIMIT_W'(dist_in) > produced_ff;
      stat.copy_one  = cnt_ff == lzfgd_pkg::LEN_W'(1);
      stat.copy_zero = cnt_ff == '0;
      stat.bit_wrap  = bit_idx_ff == lzfgd_pkg::BIT_TOP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= lzfgd_pkg::LIMIT_RESET;
         produced_ff  <= '0;
         bit_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            limit_ff <= csr_out_limit;
         end
         priority if (cmd.clear_stream) begin
            produced_ff <= '0;
         end else if (data_emit) begin
            produced_ff <= produced_inc;
         end
         priority if (cmd.clear_stream || cmd.load_flag) begin
            bit_idx_ff <= '0;
         end else if (cmd.adv_bit) begin
            bit_idx_ff <= bit_idx_ff + lzfgd_pkg::BIT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         eoi_ff     <= req_end_of_input;
      end
      if (cmd.load_flag) begin
         flag_ff <= in_byte_ff;
      end
      if (cmd.load_ref) begin
         ref_hi_ff <= in_byte_ff;
      end
      if (cmd.start_copy) begin
         dist_ff <= dist_in;
         cnt_ff  <= lzfgd_pkg::LEN_W'(ref_hi_ff[7:4]) + lzfgd_pkg::LEN_BIAS;
      end else if (cmd.emit && cmd.emit_src == lzfgd_pkg::SRC_MEM) begin
         cnt_ff <= cnt_ff - lzfgd_pkg::LEN_W'(1);
      end
      if (cmd.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= cmd.emit_last;
         unique case (cmd.emit_src)
            lzfgd_pkg::SRC_OK:  rsp_kind_ff <= lzfgd_pkg::KIND_OK;
            lzfgd_pkg::SRC_ERR: rsp_kind_ff <= lzfgd_pkg::KIND_ERR;
            default:            rsp_kind_ff <= lzfgd_pkg::KIND_DATA;
         endcase
      end
   end

   // history window
   always_ff @(posedge clock) begin
      if (data_emit) begin
         window_mem[produced_ff[AW-1:0]] <= emit_byte;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= window_mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule
